// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the checker file bmad_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPL(lbl, clk, rst, cond, conseq) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(lbl, clk, rst, cond, conseq) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("assertion failed: next-cycle implication");

// Next-cycle implication, checked during reset too.
`define ASSERT_NEXT_ALWAYS(lbl, clk, cond, conseq) \
  lbl: assert property (@(posedge clk) (cond) |=> (conseq)) \
    else $error("assertion failed: next-cycle implication in reset");

`endif

// ----- design/bmad_pkg.sv -----
// ----------------------------------------------------------------------------
// bmad_pkg
// Types and constants of the banked memory address decoder.
// ----------------------------------------------------------------------------
package bmad_pkg;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_VIDEO = 2'd2;

  typedef enum logic [3:0] {
    TGT_RAM   = 4'd0,
    TGT_BASIC = 4'd1,
    TGT_KERN  = 4'd2,
    TGT_CHAR  = 4'd3,
    TGT_VIDEO = 4'd4,
    TGT_SOUND = 4'd5,
    TGT_COLOR = 4'd6,
    TGT_PORTA = 4'd7,
    TGT_PORTB = 4'd8,
    TGT_NONE  = 4'd9
  } target_t;

  typedef enum logic [2:0] {
    REG_RAM   = 3'd0,
    REG_BASIC = 3'd1,
    REG_KERN  = 3'd2,
    REG_CHAR  = 3'd3,
    REG_IO    = 3'd4
  } region_t;

  localparam logic [15:0] PORT_DIR_ADDR  = 16'h0000;
  localparam logic [15:0] PORT_DATA_ADDR = 16'h0001;
  // Low three bits of 0x2F and 0x37.
  localparam logic [2:0]  PORT_DIR_RESET  = 3'b111;
  localparam logic [2:0]  PORT_DATA_RESET = 3'b111;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  data;
    logic [1:0]  video_bank;
  } req_t;

  typedef struct packed {
    logic [3:0]  target;
    logic [15:0] offset;
    logic        write_strobe;
    logic [7:0]  write_data;
    logic        nibble_read;
    logic        open_bus;
    logic [2:0]  map_select;
  } rsp_t;

  // Region of a 4 KB page under one of the eight maps.
  function automatic region_t region_of(logic [2:0] map_sel, logic [3:0] page);
    region_t r;
    r = REG_RAM;
    case (page)
      4'hA, 4'hB: if (map_sel[1:0] == 2'b11) r = REG_BASIC;
      4'hD: if (map_sel[1:0] != 2'b00) r = map_sel[2] ? REG_IO : REG_CHAR;
      4'hE, 4'hF: if (map_sel[1]) r = REG_KERN;
      default: r = REG_RAM;
    endcase
    return r;
  endfunction

endpackage

// ----- design/bmad_req_if.sv -----
// ----------------------------------------------------------------------------
// bmad_req_if
// Valid/ready channel carrying one bus access.
// ----------------------------------------------------------------------------
interface bmad_req_if import bmad_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- design/bmad_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bmad_rsp_if
// Valid/ready channel carrying one decoded access.
// ----------------------------------------------------------------------------
interface bmad_rsp_if import bmad_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- design/bmad_port_regs.sv -----
// ----------------------------------------------------------------------------
// bmad_port_regs
// Processor port direction/data bits and the effective map index.
// ----------------------------------------------------------------------------
module bmad_port_regs import bmad_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  req_t       item,
  output logic [2:0] map_select
);

  logic [2:0] port_dir;
  logic [2:0] port_dat;
  logic [2:0] port_dir_next;
  logic [2:0] port_dat_next;
  logic       is_write;

  assign is_write = (item.command == CMD_WRITE);

  always_comb begin
    port_dir_next = port_dir;
    port_dat_next = port_dat;
    if (is_write && item.address == PORT_DIR_ADDR) port_dir_next = item.data[2:0];
    if (is_write && item.address == PORT_DATA_ADDR) port_dat_next = item.data[2:0];
  end

  // Inputs float high: undriven bits read as one.
  assign map_select = (port_dat_next & port_dir_next) | ~port_dir_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      port_dir <= PORT_DIR_RESET;
      port_dat <= PORT_DATA_RESET;
    end else if (advance) begin
      port_dir <= port_dir_next;
      port_dat <= port_dat_next;
    end
  end

endmodule

// ----- design/bmad_decode.sv -----
// ----------------------------------------------------------------------------
// bmad_decode
// Decodes one access into target, offset and strobes under a given map.
// ----------------------------------------------------------------------------
module bmad_decode import bmad_pkg::*; (
  input  req_t       item,
  input  logic [2:0] map_select,
  output rsp_t       result
);

  typedef struct packed {
    target_t     target;
    logic [15:0] offset;
  } io_hit_t;

  function automatic io_hit_t io_decode(logic [15:0] a);
    io_hit_t h;
    h.target = TGT_NONE;
    h.offset = 16'h0000;
    case (a[11:10])
      2'b00: begin
        h.target = TGT_VIDEO;
        h.offset = {10'd0, a[5:0]};
      end
      2'b01: begin
        h.target = TGT_SOUND;
        h.offset = {11'd0, a[4:0]};
      end
      2'b10: begin
        h.target = TGT_COLOR;
        h.offset = {6'd0, a[9:0]};
      end
      default: begin
        if (a[9:8] == 2'b00) begin
          h.target = TGT_PORTA;
          h.offset = {12'd0, a[3:0]};
        end else if (a[9:8] == 2'b01) begin
          h.target = TGT_PORTB;
          h.offset = {12'd0, a[3:0]};
        end
      end
    endcase
    return h;
  endfunction

  logic [15:0] a;
  region_t     region;
  io_hit_t     io_hit;
  target_t     tgt;

  assign a      = item.address;
  assign region = region_of(map_select, a[15:12]);
  assign io_hit = io_decode(a);

  always_comb begin
    tgt                 = TGT_NONE;
    result.offset       = 16'h0000;
    result.write_strobe = 1'b0;
    result.write_data   = 8'h00;
    result.nibble_read  = 1'b0;
    result.open_bus     = 1'b0;
    case (item.command)
      CMD_READ: begin
        case (region)
          REG_KERN: begin
            tgt           = TGT_KERN;
            result.offset = {3'd0, a[12:0]};
          end
          REG_BASIC: begin
            tgt           = TGT_BASIC;
            result.offset = {3'd0, a[12:0]};
          end
          REG_CHAR: begin
            tgt           = TGT_CHAR;
            result.offset = {4'd0, a[11:0]};
          end
          REG_IO: begin
            tgt                = io_hit.target;
            result.offset      = io_hit.offset;
            result.nibble_read = (io_hit.target == TGT_COLOR);
            result.open_bus    = (io_hit.target == TGT_NONE);
          end
          default: begin
            tgt           = TGT_RAM;
            result.offset = a;
          end
        endcase
      end
      CMD_WRITE: begin
        case (region)
          REG_CHAR: begin
            if (a[11:10] == 2'b10) begin
              tgt           = TGT_COLOR;
              result.offset = {6'd0, a[9:0]};
            end else begin
              tgt           = TGT_RAM;
              result.offset = a;
            end
          end
          REG_IO: begin
            tgt           = io_hit.target;
            result.offset = io_hit.offset;
          end
          // Writes under rom land in the ram underneath.
          default: begin
            tgt           = TGT_RAM;
            result.offset = a;
          end
        endcase
        if (tgt != TGT_NONE) begin
          result.write_strobe = 1'b1;
          result.write_data   = (tgt == TGT_COLOR) ? {4'h0, item.data[3:0]} : item.data;
        end
      end
      CMD_VIDEO: begin
        if (a[13:12] == 2'b01 && !item.video_bank[0]) begin
          tgt           = TGT_CHAR;
          result.offset = {4'd0, a[11:0]};
        end else begin
          tgt           = TGT_RAM;
          result.offset = {item.video_bank, a[13:0]};
        end
      end
      default: begin
        tgt = TGT_NONE;
      end
    endcase
    result.target     = tgt;
    result.map_select = map_select;
  end

endmodule

// ----- design/banked_memory_address_decoder.sv -----
// ----------------------------------------------------------------------------
// banked_memory_address_decoder
// Processor port bank decoder: input register, decode, result register.
//
//   channel  direction  payload
//   req      in         command, address, data, video_bank
//   rsp      out        target, offset, write_strobe, write_data,
//                       nibble_read, open_bus, map_select
//
// One transaction per cycle sustained while the receiver does not stall; an
// accepted access passes the input register, then the result register.
// Port direction/data bits update as a write moves into the result register.
// Synchronous reset clears both stages and sets the port bits to all ones.
// A stalled result holds; the input register keeps accepting as long as
// the result stage can take its contents.
// ----------------------------------------------------------------------------
module banked_memory_address_decoder import bmad_pkg::*; (
  input logic         clk,
  input logic         rst,
  bmad_req_if.sink    req,
  bmad_rsp_if.source  rsp
);

  logic       s1_valid;
  req_t       s1_item;
  logic       out_valid;
  rsp_t       out_item;
  logic       out_ready;
  logic       in_ready;
  logic       advance;
  logic [2:0] map_select;
  rsp_t       decoded;

  assign out_ready = !out_valid || rsp.ready;
  assign in_ready  = !rst && (!s1_valid || out_ready);
  assign advance   = s1_valid && out_ready;

  assign req.ready   = in_ready;
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && in_ready) s1_item <= req.payload;
  end

  bmad_port_regs u_port_regs (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .item       (s1_item),
    .map_select (map_select)
  );

  bmad_decode u_decode (
    .item       (s1_item),
    .map_select (map_select),
    .result     (decoded)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_item <= decoded;
  end

endmodule

// ----- design/bmad_checker.sv -----
// ----------------------------------------------------------------------------
// bmad_checker
// Port-level assertions for the banked memory address decoder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmad_checker import bmad_pkg::*; (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_payload
);

  logic stalled;
  logic none_hit;
  logic none_clean;

  assign stalled    = rsp_valid && !rsp_ready;
  assign none_hit   = rsp_valid && (rsp_payload.target == TGT_NONE);
  assign none_clean = (rsp_payload.offset == 16'h0000) && !rsp_payload.write_strobe &&
                      (rsp_payload.write_data == 8'h00) && !rsp_payload.nibble_read;

  // Hold a stalled result.
  `ASSERT_NEXT(a_rsp_hold, clk, rst, stalled, rsp_valid)
  `ASSERT_NEXT(a_rsp_stable, clk, rst, stalled, $stable(rsp_payload))
  // Drop any result while in reset.
  `ASSERT_NEXT_ALWAYS(a_rsp_reset, clk, rst, !rsp_valid)
  // A miss carries no offset, no write and no nibble mask.
  `ASSERT_IMPL(a_none_clean, clk, rst, none_hit, none_clean)

endmodule

bind banked_memory_address_decoder bmad_checker u_bmad_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);

// ----- sim/bmad_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// bmad_tb_pkg
// Scoreboard for the banked memory address decoder. It keeps its own copy of
// the processor port bits, decodes every accepted access into the expected
// result and checks the results in order, field by field.
// ----------------------------------------------------------------------------
package bmad_tb_pkg;
  import bmad_pkg::*;

  // Command code with no access behind it.
  localparam logic [1:0] CMD_NONE = 2'd3;

  class decode_scoreboard;
    logic [2:0]  dir_bits;
    logic [2:0]  data_bits;
    rsp_t        expected_decodes[$];
    int unsigned errors;

    function new();
      dir_bits  = PORT_DIR_RESET;
      data_bits = PORT_DATA_RESET;
      errors    = 0;
    endfunction

    function int unsigned pending();
      return expected_decodes.size();
    endfunction

    // Undriven direction bits read back as ones.
    function logic [2:0] map_index();
      return (data_bits & dir_bits) | ~dir_bits;
    endfunction

    function region_t page_region(logic [2:0] map_sel, logic [3:0] page);
      region_t r;
      r = REG_RAM;
      if ((page == 4'hA || page == 4'hB) && (map_sel == 3'd3 || map_sel == 3'd7))
        r = REG_BASIC;
      if ((page == 4'hE || page == 4'hF) && map_sel[1])
        r = REG_KERN;
      if (page == 4'hD) begin
        case (map_sel)
          3'd1, 3'd2, 3'd3: r = REG_CHAR;
          3'd5, 3'd6, 3'd7: r = REG_IO;
          default: r = REG_RAM;
        endcase
      end
      return r;
    endfunction

    function void io_page(logic [15:0] a, output target_t t, output logic [15:0] off);
      off = '0;
      if (a < 16'hD400) begin
        t = TGT_VIDEO;
        off = {10'd0, a[5:0]};
      end else if (a < 16'hD800) begin
        t = TGT_SOUND;
        off = {11'd0, a[4:0]};
      end else if (a < 16'hDC00) begin
        t = TGT_COLOR;
        off = a - 16'hD800;
      end else if (a < 16'hDD00) begin
        t = TGT_PORTA;
        off = {12'd0, a[3:0]};
      end else if (a < 16'hDE00) begin
        t = TGT_PORTB;
        off = {12'd0, a[3:0]};
      end else begin
        t = TGT_NONE;
      end
    endfunction

    // Decode one access; port register writes take effect before the lookup.
    function rsp_t decode_access(req_t q);
      rsp_t        e;
      region_t     r;
      target_t     t;
      logic [15:0] a;
      logic [15:0] off;
      e   = '0;
      a   = q.address;
      t   = TGT_NONE;
      off = '0;
      case (q.command)
        CMD_READ: begin
          r = page_region(map_index(), a[15:12]);
          if (a < 16'hA000 || r == REG_RAM) begin
            t = TGT_RAM;
            off = a;
          end else if (r == REG_KERN) begin
            t = TGT_KERN;
            off = a - 16'hE000;
          end else if (r == REG_BASIC) begin
            t = TGT_BASIC;
            off = a - 16'hA000;
          end else if (r == REG_CHAR) begin
            t = TGT_CHAR;
            off = a - 16'hD000;
          end else begin
            io_page(a, t, off);
            e.nibble_read = (t == TGT_COLOR);
            e.open_bus    = (t == TGT_NONE);
          end
        end
        CMD_WRITE: begin
          if (a == PORT_DIR_ADDR) dir_bits = q.data[2:0];
          if (a == PORT_DATA_ADDR) data_bits = q.data[2:0];
          r = page_region(map_index(), a[15:12]);
          e.write_strobe = 1'b1;
          e.write_data   = q.data;
          if (a < 16'hA000 || (r != REG_CHAR && r != REG_IO)) begin
            // ROM regions take writes into the RAM underneath
            t = TGT_RAM;
            off = a;
          end else if (r == REG_CHAR) begin
            if (a >= 16'hD800 && a < 16'hDC00) begin
              t = TGT_COLOR;
              off = a - 16'hD800;
            end else begin
              t = TGT_RAM;
              off = a;
            end
          end else begin
            io_page(a, t, off);
          end
          if (t == TGT_COLOR) e.write_data = {4'h0, q.data[3:0]};
          if (t == TGT_NONE) begin
            e.write_strobe = 1'b0;
            e.write_data   = '0;
          end
        end
        CMD_VIDEO: begin
          // Character ROM shadows 0x1000-0x1FFF of the even banks
          if (a[13:12] == 2'b01 && !q.video_bank[0]) begin
            t = TGT_CHAR;
            off = {4'h0, a[11:0]};
          end else begin
            t = TGT_RAM;
            off = {q.video_bank, a[13:0]};
          end
        end
        default: ;
      endcase
      e.target     = t;
      e.offset     = off;
      e.map_select = map_index();
      return e;
    endfunction

    function void note_access(req_t q);
      expected_decodes.push_back(decode_access(q));
    endfunction

    function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_decode(rsp_t got);
      rsp_t e;
      if (expected_decodes.size() == 0) begin
        $error("decode result with no access outstanding");
        errors++;
        return;
      end
      e = expected_decodes.pop_front();
      compare_field("target", e.target, got.target);
      compare_field("offset", e.offset, got.offset);
      compare_field("write_strobe", e.write_strobe, got.write_strobe);
      compare_field("write_data", e.write_data, got.write_data);
      compare_field("nibble_read", e.nibble_read, got.nibble_read);
      compare_field("open_bus", e.open_bus, got.open_bus);
      compare_field("map_select", e.map_select, got.map_select);
    endfunction
  endclass

endpackage

// ----- sim/tb_banked_memory_address_decoder.sv -----
// ----------------------------------------------------------------------------
// tb_banked_memory_address_decoder
// Drives directed and random bus accesses through the decoder with bursty
// requests and a stalling receiver, and checks every decoded result against
// the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_banked_memory_address_decoder import bmad_pkg::*; import bmad_tb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bmad_req_if req ();
  bmad_rsp_if rsp ();

  banked_memory_address_decoder DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  decode_scoreboard decodes = new();
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  int unsigned stall_pct = 0;
  int unsigned phase_left = 0;

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req.valid && req.ready) decodes.note_access(req.payload);
      if (rsp.valid && rsp.ready) decodes.check_decode(rsp.payload);
    end
  end

  // Receiver: stall rate changes from phase to phase, some phases never stall.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 80;
        endcase
      end else begin
        phase_left--;
      end
      rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic req_t make_access(logic [1:0] cmd, logic [15:0] a, logic [7:0] d,
                                       logic [1:0] bank);
    req_t q;
    q.command    = cmd;
    q.address    = a;
    q.data       = d;
    q.video_bank = bank;
    return q;
  endfunction

  function automatic req_t random_access();
    req_t q;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) q.command = CMD_READ;
    else if (pick < 72) q.command = CMD_WRITE;
    else if (pick < 95) q.command = CMD_VIDEO;
    else q.command = CMD_NONE;
    q.data       = 8'($urandom);
    q.video_bank = 2'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 12) q.address = 16'($urandom_range(0, 1));
    else if (pick < 50) q.address = {4'hD, 12'($urandom)};
    else if (pick < 75) q.address = 16'($urandom_range(16'hA000, 16'hFFFF));
    else q.address = 16'($urandom);
    return q;
  endfunction

  // Hold the transaction until accepted; called at a rising edge.
  task automatic send_access(req_t q);
    req.payload <= q;
    req.valid   <= 1'b1;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic push_access(req_t q);
    int unsigned gap;
    send_access(q);
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_decodes();
    req.valid <= 1'b0;
    @(posedge clk);
    while (decodes.pending() != 0) @(posedge clk);
  endtask

  initial begin
    req_t directed[$];
    req.valid   = 1'b0;
    req.payload = '0;
    rsp.ready   = 1'b0;

    // Reset map: basic, I/O and kernel all banked in
    directed.push_back(make_access(CMD_READ, 16'h0000, 8'h00, 2'd0));
    directed.push_back(make_access(CMD_READ, 16'h9FFF, 8'h00, 2'd0));
    directed.push_back(make_access(CMD_READ, 16'hA123, 8'h00, 2'd0));
    directed.push_back(make_access(CMD_READ, 16'hC000, 8'h00, 2'd0));
    directed.push_back(make_access(CMD_READ, 16'hD3FF, 8'h00, 2'd0));
    directed.push_back(make_access(CMD_READ, 16'hD7FF, 8'h00, 2'd0));
    directed.push_back(make_access(CMD_READ, 16'hDBFF, 8'h00, 2'd0));
    directed.push_back(make_access(CMD_READ, 16'hDCFF, 8'h00, 2'd0));
    directed.push_back(make_access(CMD_READ, 16'hDD0F, 8'h00, 2'd0));
    directed.push_back(make_access(CMD_READ, 16'hDFFF, 8'h00, 2'd0));
    directed.push_back(make_access(CMD_READ, 16'hFFFF, 8'h00, 2'd0));
    directed.push_back(make_access(CMD_WRITE, 16'hDA55, 8'hFF, 2'd0));
    directed.push_back(make_access(CMD_WRITE, 16'hDE00, 8'hAA, 2'd0));
    directed.push_back(make_access(CMD_WRITE, 16'hE000, 8'h5A, 2'd0));
    // All-RAM map, then I/O without basic, then character ROM map
    directed.push_back(make_access(CMD_WRITE, PORT_DATA_ADDR, 8'h30, 2'd0));
    directed.push_back(make_access(CMD_READ, 16'hD000, 8'h00, 2'd0));
    directed.push_back(make_access(CMD_WRITE, PORT_DATA_ADDR, 8'h35, 2'd0));
    directed.push_back(make_access(CMD_READ, 16'hB000, 8'h00, 2'd0));
    directed.push_back(make_access(CMD_WRITE, PORT_DATA_ADDR, 8'h33, 2'd0));
    directed.push_back(make_access(CMD_READ, 16'hD800, 8'h00, 2'd0));
    directed.push_back(make_access(CMD_WRITE, 16'hD800, 8'hC3, 2'd0));
    directed.push_back(make_access(CMD_WRITE, 16'hD7FF, 8'h81, 2'd0));
    // Clear direction: every port bit floats high
    directed.push_back(make_access(CMD_WRITE, PORT_DIR_ADDR, 8'hF8, 2'd0));
    directed.push_back(make_access(CMD_VIDEO, 16'h1000, 8'h00, 2'd0));
    directed.push_back(make_access(CMD_VIDEO, 16'h1FFF, 8'h00, 2'd2));
    directed.push_back(make_access(CMD_VIDEO, 16'h1000, 8'h00, 2'd1));
    directed.push_back(make_access(CMD_VIDEO, 16'hFFFF, 8'hFF, 2'd3));
    directed.push_back(make_access(CMD_NONE, 16'hFFFF, 8'hFF, 2'd3));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) push_access(directed[i]);
    drain_decodes();

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain_decodes();
      push_access(random_access());
    end

    drain_decodes();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (decodes.errors == 0 && decodes.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
